// File: hw/rtl/meai_pkg.sv
// Shared constants, widths and register indexes for the masked edge-average interpolator.
package meai_pkg;

  localparam int INTEGER_BITS  = 12;
  localparam int FRACTION_BITS = 8;
  localparam int PIXEL_BITS    = 16;

  localparam int POS_W    = INTEGER_BITS + FRACTION_BITS;
  localparam int DIM_W    = 13;
  localparam int MARGIN_W = 12;
  localparam int CFG_W    = DIM_W;
  localparam int CFG_IDX_W = 3;

  localparam int EDGES = 4;
  localparam int CNT_W = 3;

  // stream packing
  localparam int IN_FIELD_BITS  = 2 * POS_W + EDGES * PIXEL_BITS;
  localparam int IN_TDATA_W     = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_W     = EDGES;
  localparam int OUT_TDATA_W    = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_W    = 1;
  localparam int X_LO  = 0;
  localparam int Z_LO  = POS_W;
  localparam int BL_LO = 2 * POS_W;
  localparam int BR_LO = BL_LO + PIXEL_BITS;
  localparam int TL_LO = BR_LO + PIXEL_BITS;
  localparam int TR_LO = TL_LO + PIXEL_BITS;

  // edge order inside the datapath
  localparam int E_BOTTOM = 0;
  localparam int E_TOP    = 1;
  localparam int E_LEFT   = 2;
  localparam int E_RIGHT  = 3;

  // signed width for the border compare
  localparam int BC_W = ((INTEGER_BITS > DIM_W) ? INTEGER_BITS : DIM_W) + 2;

  // datapath widths
  localparam int DIFF_W = PIXEL_BITS + 1;
  localparam int MUL_W  = DIFF_W + FRACTION_BITS + 1;
  localparam int TERM_W = PIXEL_BITS + FRACTION_BITS;
  localparam int SUM_W  = TERM_W + 2;
  localparam int MAG_W  = SUM_W - FRACTION_BITS;

  // floor(a / 3) by reciprocal, corrected by one compare later
  localparam int RECIP_SH = PIXEL_BITS + 1;
  localparam logic [RECIP_SH-1:0] RECIP3 = RECIP_SH'((longint'(1) << RECIP_SH) / 3);

  localparam int NSTAGE = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_MARGIN_LEFT   = 3'd2,
    CFG_MARGIN_RIGHT  = 3'd3,
    CFG_MARGIN_TOP    = 3'd4,
    CFG_MARGIN_BOTTOM = 3'd5
  } cfg_idx_t;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(4096);

endpackage

// File: hw/rtl/masked_edge_average_interpolator_core.sv
// Masked edge-average bilinear interpolator: six-stage pipeline, stream in and out.
//
// One request in, one result out, one request per clock sustained while out_tready
// is high. Stages: edge differences and border check, edge multiplies, four-term sum,
// magnitude, divide by edge count (reciprocal multiply for the odd count above one), then
// correction, sign and output register. Each stage has its own valid bit and moves
// when the stage after it is empty or moving, so bubbles are squeezed out under
// back-pressure. Indexes above five are ignored. The user must write the registers
// (cfg_we/cfg_index/cfg_data) only while the pipeline is empty; no check enforces it.
module masked_edge_average_interpolator_core
  import meai_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // x_position, z_position, value_bottom_left, value_bottom_right,
  // value_top_left, value_top_right
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // valid_bottom_left, valid_bottom_right, valid_top_left, valid_top_right
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // interpolated_value
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // result_valid
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  logic [DIM_W-1:0]    width_r, height_r;
  logic [MARGIN_W-1:0] mleft_r, mright_r, mtop_r, mbottom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= DIM_RESET;
      height_r  <= DIM_RESET;
      mleft_r   <= '0;
      mright_r  <= '0;
      mtop_r    <= '0;
      mbottom_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:   width_r   <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  height_r  <= cfg_data[DIM_W-1:0];
        CFG_MARGIN_LEFT:   mleft_r   <= cfg_data[MARGIN_W-1:0];
        CFG_MARGIN_RIGHT:  mright_r  <= cfg_data[MARGIN_W-1:0];
        CFG_MARGIN_TOP:    mtop_r    <= cfg_data[MARGIN_W-1:0];
        CFG_MARGIN_BOTTOM: mbottom_r <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic [NSTAGE:1] vld_r;
  logic [NSTAGE:1] adv;

  always_comb begin
    adv[NSTAGE] = !vld_r[NSTAGE] || out_tready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[1]) vld_r[1] <= in_tvalid;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign in_tready  = adv[1];
  assign out_tvalid = vld_r[NSTAGE];

  // stage 1: unpack, border check, edge differences
  logic [POS_W-1:0]             x_pos, z_pos;
  logic [INTEGER_BITS-1:0]      col_l, line_b;
  logic signed [PIXEL_BITS-1:0] pix_bl, pix_br, pix_tl, pix_tr;
  logic                         v_bl, v_br, v_tl, v_tr;
  logic signed [BC_W-1:0]       right_lim, bottom_lim, col_r, line_t;
  logic                         in_area;
  logic [EDGES-1:0]             use1;
  logic signed [PIXEL_BITS-1:0] base1 [EDGES];
  logic signed [PIXEL_BITS-1:0] tip1  [EDGES];
  logic [FRACTION_BITS-1:0]     frac1 [EDGES];

  always_comb begin
    x_pos  = in_tdata[X_LO +: POS_W];
    z_pos  = in_tdata[Z_LO +: POS_W];
    col_l  = x_pos[POS_W-1:FRACTION_BITS];
    line_b = z_pos[POS_W-1:FRACTION_BITS];
    pix_bl = $signed(in_tdata[BL_LO +: PIXEL_BITS]);
    pix_br = $signed(in_tdata[BR_LO +: PIXEL_BITS]);
    pix_tl = $signed(in_tdata[TL_LO +: PIXEL_BITS]);
    pix_tr = $signed(in_tdata[TR_LO +: PIXEL_BITS]);
    v_bl   = in_tuser[0];
    v_br   = in_tuser[1];
    v_tl   = in_tuser[2];
    v_tr   = in_tuser[3];

    right_lim  = $signed(BC_W'(width_r)) - $signed(BC_W'(mright_r));
    bottom_lim = $signed(BC_W'(height_r)) - $signed(BC_W'(mbottom_r));
    col_r      = $signed(BC_W'(col_l) + BC_W'(1));
    line_t     = $signed(BC_W'(line_b) + BC_W'(1));
    in_area = (BC_W'(col_l) >= BC_W'(mleft_r)) && (col_r < right_lim)
           && (BC_W'(line_b) >= BC_W'(mtop_r)) && (line_t < bottom_lim);

    use1[E_BOTTOM] = v_bl && v_br;
    use1[E_TOP]    = v_tl && v_tr;
    use1[E_LEFT]   = v_bl && v_tl;
    use1[E_RIGHT]  = v_br && v_tr;

    base1[E_BOTTOM] = pix_bl;  tip1[E_BOTTOM] = pix_br;
    base1[E_TOP]    = pix_tl;  tip1[E_TOP]    = pix_tr;
    base1[E_LEFT]   = pix_bl;  tip1[E_LEFT]   = pix_tl;
    base1[E_RIGHT]  = pix_br;  tip1[E_RIGHT]  = pix_tr;
    frac1[E_BOTTOM] = x_pos[FRACTION_BITS-1:0];
    frac1[E_TOP]    = x_pos[FRACTION_BITS-1:0];
    frac1[E_LEFT]   = z_pos[FRACTION_BITS-1:0];
    frac1[E_RIGHT]  = z_pos[FRACTION_BITS-1:0];
  end

  logic signed [PIXEL_BITS-1:0] s1_base_r [EDGES];
  logic signed [DIFF_W-1:0]     s1_diff_r [EDGES];
  logic [FRACTION_BITS-1:0]     s1_frac_r [EDGES];
  logic [EDGES-1:0]             s1_use_r;
  logic [CNT_W-1:0]             s1_cnt_r;
  logic                         s1_ok_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int e = 0; e < EDGES; e++) begin
        s1_base_r[e] <= base1[e];
        s1_diff_r[e] <= DIFF_W'(tip1[e]) - DIFF_W'(base1[e]);
        s1_frac_r[e] <= frac1[e];
      end
      s1_use_r <= use1;
      s1_cnt_r <= CNT_W'(use1[0]) + CNT_W'(use1[1]) + CNT_W'(use1[2]) + CNT_W'(use1[3]);
      s1_ok_r  <= in_area && (|use1);
    end
  end

  // stage 2: edge terms, base scaled plus difference times fraction
  logic signed [MUL_W-1:0] term2 [EDGES];

  always_comb begin
    for (int e = 0; e < EDGES; e++) begin
      term2[e] = s1_diff_r[e] * $signed({1'b0, s1_frac_r[e]})
               + MUL_W'($signed({s1_base_r[e], {FRACTION_BITS{1'b0}}}));
    end
  end

  logic signed [TERM_W-1:0] s2_term_r [EDGES];
  logic [CNT_W-1:0]         s2_cnt_r;
  logic                     s2_ok_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int e = 0; e < EDGES; e++) begin
        s2_term_r[e] <= s1_use_r[e] ? $signed(term2[e][TERM_W-1:0]) : '0;
      end
      s2_cnt_r <= s1_cnt_r;
      s2_ok_r  <= s1_ok_r;
    end
  end

  // stage 3: sum of used terms
  logic signed [SUM_W-1:0] s3_sum_r;
  logic [CNT_W-1:0]        s3_cnt_r;
  logic                    s3_ok_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_sum_r <= SUM_W'(s2_term_r[0]) + SUM_W'(s2_term_r[1])
                + SUM_W'(s2_term_r[2]) + SUM_W'(s2_term_r[3]);
      s3_cnt_r <= s2_cnt_r;
      s3_ok_r  <= s2_ok_r;
    end
  end

  // stage 4: magnitude, drop fraction bits
  logic [SUM_W-1:0] mag4;

  always_comb begin
    mag4 = s3_sum_r[SUM_W-1] ? SUM_W'(-s3_sum_r) : SUM_W'(s3_sum_r);
  end

  logic [MAG_W-1:0] s4_mag_r;
  logic             s4_neg_r;
  logic [CNT_W-1:0] s4_cnt_r;
  logic             s4_ok_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_mag_r <= mag4[SUM_W-1:FRACTION_BITS];
      s4_neg_r <= s3_sum_r[SUM_W-1];
      s4_cnt_r <= s3_cnt_r;
      s4_ok_r  <= s3_ok_r;
    end
  end

  // stage 5: divide by edge count
  logic [2*RECIP_SH-1:0] prod5;
  logic [MAG_W-1:0]      quo5;

  always_comb begin
    prod5 = s4_mag_r[RECIP_SH-1:0] * RECIP3;
    unique case (s4_cnt_r)
      CNT_W'(2): quo5 = s4_mag_r >> 1;
      CNT_W'(3): quo5 = MAG_W'(prod5[2*RECIP_SH-1:RECIP_SH]);
      CNT_W'(4): quo5 = s4_mag_r >> 2;
      default:   quo5 = s4_mag_r;
    endcase
  end

  logic [MAG_W-1:0] s5_quo_r;
  logic [MAG_W-1:0] s5_mag_r;
  logic             s5_by3_r;
  logic             s5_neg_r;
  logic             s5_ok_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_quo_r <= quo5;
      s5_mag_r <= s4_mag_r;
      s5_by3_r <= (s4_cnt_r == CNT_W'(3));
      s5_neg_r <= s4_neg_r;
      s5_ok_r  <= s4_ok_r;
    end
  end

  // stage 6: reciprocal correction, sign, output register
  logic [MAG_W+1:0]      rem6;
  logic [MAG_W-1:0]      quo6;
  logic [PIXEL_BITS-1:0] val6;

  always_comb begin
    rem6 = (MAG_W+2)'(s5_mag_r) - ((MAG_W+2)'(s5_quo_r) << 1) - (MAG_W+2)'(s5_quo_r);
    quo6 = s5_quo_r;
    if (s5_by3_r && (rem6 >= (MAG_W+2)'(3))) quo6 = s5_quo_r + MAG_W'(1);
    val6 = s5_neg_r ? PIXEL_BITS'(-quo6) : quo6[PIXEL_BITS-1:0];
    if (!s5_ok_r) val6 = '0;
  end

  logic [PIXEL_BITS-1:0] out_val_r;
  logic                  out_ok_r;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      out_val_r <= val6;
      out_ok_r  <= s5_ok_r;
    end
  end

  assign out_tdata = OUT_TDATA_W'(out_val_r);
  assign out_tuser = OUT_TUSER_W'(out_ok_r);

endmodule
